// File: rtl/core/aesh_pkg.sv
// ----------------------------------------------------------------------------
// aesh_pkg
// Shared constants, types and the AES round function for the lane hash unit.
// ----------------------------------------------------------------------------
package aesh_pkg;

  localparam int unsigned INIT_ROUNDS      = 12;
  localparam int unsigned MAX_DIGEST_BYTES = 64;
  localparam int unsigned CNT_W            = $clog2(INIT_ROUNDS + 1);
  localparam int unsigned NUM_LANES        = 8;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_WORD  = 2'd1;
  localparam logic [1:0] FUNC_FIN   = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;
  localparam logic [2:0] REG_DLEN = 3'd5;

  localparam logic [127:0] CONST_A = {64'h6279e99059372215, 64'h0d08050302010100};
  localparam logic [127:0] CONST_B = {64'hdd28b57342311120, 64'hf12fc26d55183ddb};
  localparam logic [7:0]   CTX_MARK = 8'h80;

  typedef enum logic [1:0] {
    MSG_CONST,
    MSG_BUF,
    MSG_T
  } msg_sel_e;

  typedef struct packed {
    logic     init;
    logic     word;
    logic     upd;
    msg_sel_e msg_sel;
    logic     len;
    logic     fin;
    logic     out_load;
    logic [1:0] out_k;
    logic [3:0] out_vb;
    logic     out_last;
  } aesh_cmd_t;

  typedef struct packed {
    logic       full;
    logic       wpos_nz;
    logic [6:0] dlen;
  } aesh_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_round(logic [127:0] s, logic [127:0] rk);
    logic [7:0]   b [16];
    logic [7:0]   x0, x1, x2, x3, t;
    logic [127:0] r;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        b[row + 4 * col] = SBOX[s[8 * (row + 4 * ((col + row) % 4)) +: 8]];
      end
    end
    for (int col = 0; col < 4; col++) begin
      x0 = b[4 * col];
      x1 = b[4 * col + 1];
      x2 = b[4 * col + 2];
      x3 = b[4 * col + 3];
      t  = x0 ^ x1 ^ x2 ^ x3;
      r[32 * col      +: 8] = x0 ^ t ^ xtime(x0 ^ x1);
      r[32 * col + 8  +: 8] = x1 ^ t ^ xtime(x1 ^ x2);
      r[32 * col + 16 +: 8] = x2 ^ t ^ xtime(x2 ^ x3);
      r[32 * col + 24 +: 8] = x3 ^ t ^ xtime(x3 ^ x0);
    end
    return r ^ rk;
  endfunction

  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    for (int j = 0; j < 8; j++) begin
      m[8 * j +: 8] = (4'(j) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: rtl/core/aesh_datapath.sv
// ----------------------------------------------------------------------------
// aesh_datapath
// Lane state, eight-lane AES update, block buffer, counters, config registers
// and the digest output register.
// ----------------------------------------------------------------------------
module aesh_datapath import aesh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        is_context_i,
  input  aesh_cmd_t   cmd_i,
  output aesh_sts_t   sts_o,
  output logic [63:0] digest_word_o,
  output logic [3:0]  valid_bytes_o,
  output logic        last_o
);

  logic [127:0] lanes_q [NUM_LANES];
  logic [127:0] lanes_d [NUM_LANES];
  logic [63:0]  buf_q [4];
  logic [2:0]   wpos_q;
  logic [63:0]  seglen_q, ctxcnt_q, msgcnt_q;
  logic [127:0] t_q;
  logic         ctx_q;
  logic         keyed_q;
  logic [63:0]  key_q [4];
  logic [6:0]   dlen_q;
  logic [63:0]  out_word_q;
  logic [3:0]   out_vb_q;
  logic         out_last_q;

  logic [127:0] m0, m1, k0, k1, chunk_a, chunk_b;
  logic [63:0]  chunk;
  logic [1:0]   slot;
  logic [3:0]   cnt_sat;

  assign k0 = keyed_q ? {key_q[1], key_q[0]} : '0;
  assign k1 = keyed_q ? {key_q[3], key_q[2]} : '0;
  assign slot    = keyed_q ? wpos_q[1:0] : {wpos_q[0], 1'b0};
  assign cnt_sat = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;

  always_comb begin
    case (cmd_i.msg_sel)
      MSG_CONST: begin m0 = CONST_A;             m1 = CONST_B;             end
      MSG_BUF:   begin m0 = {buf_q[1], buf_q[0]}; m1 = {buf_q[3], buf_q[2]}; end
      MSG_T:     begin m0 = t_q;                 m1 = t_q;                 end
      default:   begin m0 = '0;                  m1 = '0;                  end
    endcase
    lanes_d[0] = aes_round(lanes_q[NUM_LANES-1], lanes_q[0]) ^ m0;
    for (int i = 1; i < NUM_LANES; i++) begin
      lanes_d[i] = aes_round(lanes_q[i-1], lanes_q[i]);
    end
    lanes_d[4] = lanes_d[4] ^ m1;
  end

  assign chunk_a = lanes_q[1] ^ lanes_q[6] ^ (lanes_q[2] & lanes_q[3]);
  assign chunk_b = lanes_q[2] ^ lanes_q[5] ^ (lanes_q[6] & lanes_q[7]);

  always_comb begin
    case (cmd_i.out_k)
      2'd0:    chunk = chunk_a[63:0];
      2'd1:    chunk = chunk_a[127:64];
      2'd2:    chunk = chunk_b[63:0];
      default: chunk = chunk_b[127:64];
    endcase
  end

  assign sts_o.full    = keyed_q ? (wpos_q >= 3'd4) : (wpos_q >= 3'd2);
  assign sts_o.wpos_nz = (wpos_q != 3'd0);
  assign sts_o.dlen    = (dlen_q == 7'd0) ? 7'd1 :
                         (dlen_q > 7'(MAX_DIGEST_BYTES)) ? 7'(MAX_DIGEST_BYTES) : dlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LANES; i++) lanes_q[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        buf_q[i] <= '0;
        key_q[i] <= '0;
      end
      wpos_q   <= '0;
      seglen_q <= '0;
      ctxcnt_q <= '0;
      msgcnt_q <= '0;
      t_q      <= '0;
      ctx_q    <= 1'b0;
      keyed_q  <= 1'b0;
      dlen_q   <= 7'd32;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MODE: keyed_q  <= cfg_data_i[0];
          REG_KEY0: key_q[0] <= cfg_data_i;
          REG_KEY1: key_q[1] <= cfg_data_i;
          REG_KEY2: key_q[2] <= cfg_data_i;
          REG_KEY3: key_q[3] <= cfg_data_i;
          REG_DLEN: dlen_q   <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.init) begin
        lanes_q[0] <= '0;
        lanes_q[1] <= k1;
        lanes_q[2] <= k0 ^ CONST_B;
        lanes_q[3] <= k0 ^ CONST_A;
        lanes_q[4] <= '0;
        lanes_q[5] <= k0;
        lanes_q[6] <= k1 ^ CONST_A;
        lanes_q[7] <= k1 ^ CONST_B;
        for (int i = 0; i < 4; i++) buf_q[i] <= '0;
        wpos_q   <= '0;
        seglen_q <= '0;
        ctxcnt_q <= '0;
        msgcnt_q <= '0;
      end
      if (cmd_i.word) begin
        ctx_q <= is_context_i;
        if (byte_count_i != 4'd0) begin
          buf_q[slot] <= data_word_i & byte_mask(byte_count_i);
          wpos_q      <= wpos_q + 3'd1;
          seglen_q    <= seglen_q + 64'(cnt_sat);
        end
      end
      if (cmd_i.upd) begin
        for (int i = 0; i < NUM_LANES; i++) lanes_q[i] <= lanes_d[i];
        if (cmd_i.msg_sel == MSG_BUF) begin
          for (int i = 0; i < 4; i++) buf_q[i] <= '0;
          wpos_q <= '0;
        end
      end
      if (cmd_i.len) begin
        buf_q[0] <= {seglen_q[60:0], 3'b000};
        buf_q[1] <= '0;
        buf_q[2] <= '0;
        buf_q[3] <= ctx_q ? {CTX_MARK, 56'd0} : 64'd0;
        seglen_q <= '0;
        if (ctx_q) ctxcnt_q <= ctxcnt_q + 64'd1;
        else       msgcnt_q <= msgcnt_q + 64'd1;
      end
      if (cmd_i.fin) begin
        for (int i = 0; i < 4; i++) buf_q[i] <= '0;
        wpos_q   <= '0;
        seglen_q <= '0;
        t_q      <= {lanes_q[2][127:64] ^ {msgcnt_q[60:0], 3'b000},
                     lanes_q[2][63:0]   ^ {ctxcnt_q[60:0], 3'b000}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q <= chunk & byte_mask(cmd_i.out_vb);
      out_vb_q   <= cmd_i.out_vb;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign digest_word_o = out_word_q;
  assign valid_bytes_o = out_vb_q;
  assign last_o        = out_last_q;

endmodule

// File: rtl/core/aesh_ctrl.sv
// ----------------------------------------------------------------------------
// aesh_ctrl
// Sequencer for start, data word and finalize items and digest transfers.
// ----------------------------------------------------------------------------
module aesh_ctrl import aesh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [3:0] byte_count_i,
  input  logic       segment_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  aesh_sts_t  sts_i,
  output aesh_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IRUN,
    ST_FRUN,
    ST_SEG,
    ST_LEN,
    ST_ABS,
    ST_OUT
  } state_e;

  state_e         state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [6:0]     rem_q, rem_d;
  logic [1:0]     k_q, k_d;
  logic           seg_q, seg_d, wrote_q, wrote_d;
  logic           ovalid_q, ovalid_d;
  logic           accept, room;
  logic [3:0]     vb;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign room        = !ovalid_q || !out_stall_i;
  assign vb          = (rem_q >= 7'd8) ? 4'd8 : rem_q[3:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    k_d     = k_q;
    seg_d   = seg_q;
    wrote_d = wrote_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o = '0;
    cmd_o.msg_sel  = MSG_BUF;
    cmd_o.out_k    = k_q;
    cmd_o.out_vb   = vb;
    cmd_o.out_last = (rem_q <= 7'd8);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_START: begin
              cmd_o.init = 1'b1;
              cnt_d   = CNT_W'(INIT_ROUNDS - 1);
              state_d = ST_IRUN;
            end
            FUNC_WORD: begin
              cmd_o.word = 1'b1;
              seg_d   = segment_end_i;
              wrote_d = (byte_count_i != 4'd0);
              state_d = ST_SEG;
            end
            FUNC_FIN: begin
              cmd_o.fin = 1'b1;
              cnt_d   = CNT_W'(INIT_ROUNDS - 1);
              rem_d   = sts_i.dlen;
              k_d     = 2'd0;
              state_d = ST_FRUN;
            end
            default: ;
          endcase
        end
      end
      ST_IRUN, ST_FRUN: begin
        cmd_o.upd     = 1'b1;
        cmd_o.msg_sel = (state_q == ST_IRUN) ? MSG_CONST : MSG_T;
        if (cnt_q == '0) begin
          state_d = (state_q == ST_IRUN) ? ST_IDLE : ST_OUT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_SEG: begin
        if (wrote_q && sts_i.full) begin
          cmd_o.upd = 1'b1;
          wrote_d   = 1'b0;
        end else if (!seg_q) begin
          state_d = ST_IDLE;
        end else if (sts_i.wpos_nz) begin
          cmd_o.upd = 1'b1;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd_o.len = 1'b1;
        state_d   = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_OUT: begin
        if (room) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          rem_d    = rem_q - 7'(vb);
          k_d      = k_q + 2'd1;
          if (rem_q <= 7'd8) begin
            state_d = ST_IDLE;
          end else if (k_q == 2'd3) begin
            cnt_d   = '0;
            state_d = ST_FRUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      k_q      <= '0;
      seg_q    <= 1'b0;
      wrote_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      k_q      <= k_d;
      seg_q    <= seg_d;
      wrote_q  <= wrote_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// File: rtl/core/aes_round_sponge_hash_mac_unit.sv
// ----------------------------------------------------------------------------
// aes_round_sponge_hash_mac_unit
// Start: load plus 12 lane updates. Data word: buffer write, then a block
// absorb when full and, at segment end, length block and update.
// Finalize: 12 lane updates, then one word per cycle unless stalled, and
// one extra lane update per 32 bytes. One eight-lane AES update per cycle.
// Reset clears lanes, buffer, counters and config (digest length 32).
// ----------------------------------------------------------------------------
module aes_round_sponge_hash_mac_unit import aesh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        segment_end_i,
  input  logic        is_context_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [3:0]  valid_bytes_o,
  output logic        last_o
);

  aesh_cmd_t cmd;
  aesh_sts_t sts;

  assign cfg_ready_o = 1'b1;

  aesh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .byte_count_i (byte_count_i),
    .segment_end_i(segment_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  aesh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .is_context_i (is_context_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .digest_word_o(digest_word_o),
    .valid_bytes_o(valid_bytes_o),
    .last_o       (last_o)
  );

endmodule
